// File: hw/rtl/rfsp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rfsp_pkg
// Shared constants and types of the RFID serial frame parser: frame layout,
// control byte codes, item kinds and the character vector of one tag.
// ============================================================================
package rfsp_pkg;

    // Frame layout: a start byte, eight ID characters, CR, LF, ETX.
    localparam int FRAME_BYTES = 12;
    localparam int STORE_DEPTH = FRAME_BYTES - 1;
    localparam int CARD_CHARS  = 8;
    localparam int FILL_W      = 4;

    // Control byte codes.
    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] LF_BYTE    = 8'h0A;
    localparam logic [7:0] ETX_BYTE   = 8'h03;

    // Item kinds carried in tuser on the input side.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Tick counter width and reset value of the debounce register.
    localparam int          TICK_W          = 17;
    localparam int          DEBOUNCE_W      = 16;
    localparam logic [15:0] DEBOUNCE_RESET  = 16'd1500;

    // Eight ID characters, entry 0 is the first character received.
    typedef logic [CARD_CHARS-1:0][7:0] card_chars_t;

    // Decoded hex digit.
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

endpackage

// File: hw/rtl/rfsp_card_decode.sv
`timescale 1ns / 1ps
// ============================================================================
// rfsp_card_decode
// Converts the eight ID characters of a frame into the value of their
// leading run of hex digits; the run stops at the first non-hex character.
// ============================================================================
module rfsp_card_decode
    import rfsp_pkg::*;
(
    input  card_chars_t chars,
    output logic [31:0] card_value
);

    // Map one ASCII character to a hex digit.
    function automatic hex_digit_t to_hex(input logic [7:0] c);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.value = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.value = 4'(c - 8'h57);
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

    // Shift digits in while the run of hex characters lasts.
    always_comb begin
        hex_digit_t d;
        logic       in_run;
        in_run     = 1'b1;
        card_value = 32'd0;
        for (int i = 0; i < CARD_CHARS; i++) begin
            d = to_hex(chars[i]);
            if (in_run && d.valid) begin
                card_value = {card_value[27:0], d.value};
            end else begin
                in_run = 1'b0;
            end
        end
    end

endmodule

// File: hw/rtl/rfid_serial_frame_parser_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// rfid_serial_frame_parser_unit
// Frames reader UART bytes, checks the trailer, decodes the tag ID and
// debounces repeated reads of the same card against a millisecond tick.
// ============================================================================
// Usage:
//   The input stream carries one word per UART byte (tuser = 0, byte in
//   tdata[7:0]) or per millisecond tick (tuser = 1). A 0x02 byte always opens
//   a new 12-byte frame; bytes outside a frame are dropped. A full frame whose
//   last three bytes are CR, LF, ETX yields one result word: tdata holds the
//   card value, the eight raw characters and the scan total, tuser flags a
//   new scan (0 for a repeat within the debounce window). Bad frames and
//   ticks give no result.
//   Throughput is one word per cycle while results are taken. A word passes
//   an input register and a result register; all decode and debounce logic
//   sits between those registers. When the receiver stalls, the result
//   register holds and the input side keeps accepting only while the input
//   register can move on.
//   Reset (aresetn low, synchronous) closes any open frame, forgets the last
//   card, clears the tick and scan counters and sets debounce to 1500.
//   The debounce register is written with cfg_we; write it while idle.
// ============================================================================
module rfid_serial_frame_parser_unit
    import rfsp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration.
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,    // debounce limit in ticks
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,      // [7:0] rx_byte
    input  logic         s_tuser,      // [0] operation
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,      // [31:0] card_value, [95:32] card_text,
                                       // [127:96] total_scans
    output logic         m_tuser       // [0] is_new_scan
);

    logic [DEBOUNCE_W-1:0] debounce_reg;

    logic                  in_valid_reg;
    logic                  in_op_reg;
    logic [7:0]            in_byte_reg;

    logic [7:0]            store_reg [STORE_DEPTH];
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;
    logic [63:0]           last_chars_reg;
    logic                  last_valid_reg;
    logic [TICK_W-1:0]     ticks_reg;
    logic [TICK_W-1:0]     ticks_next;
    logic [31:0]           total_reg;
    logic [31:0]           total_next;

    logic                  out_valid_reg;
    logic [127:0]          out_data_reg;
    logic                  out_new_reg;

    logic                  advance;
    logic                  take;
    logic                  is_tick;
    logic                  is_start;
    logic                  frame_open;
    logic                  frame_done;
    logic                  trailer_ok;
    logic                  result;
    logic                  fresh;
    logic [FILL_W-1:0]     store_idx;
    card_chars_t           chars;
    logic [63:0]           text;
    logic [31:0]           card_value;

    // Handshake: the input register moves whenever the result register can.
    assign advance  = !out_valid_reg || m_tready;
    assign take     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
        end else if (cfg_we) begin
            debounce_reg <= cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // Classify the registered word against the frame state.
    assign is_tick    = (in_op_reg == OP_TICK);
    assign is_start   = (in_byte_reg == START_BYTE);
    assign frame_open = (fill_reg != '0) && (fill_reg < FILL_W'(FRAME_BYTES));
    assign store_idx  = fill_reg - FILL_W'(1);
    assign frame_done = !is_tick && !is_start && (fill_reg == FILL_W'(STORE_DEPTH));
    assign trailer_ok = (store_reg[8] == CR_BYTE) && (store_reg[9] == LF_BYTE) &&
                        (in_byte_reg == ETX_BYTE);
    assign result     = frame_done && trailer_ok;

    // The ID characters, first one in the top byte of the text.
    always_comb begin
        for (int i = 0; i < CARD_CHARS; i++) begin
            chars[i] = store_reg[i];
            text[63-8*i -: 8] = store_reg[i];
        end
    end

    rfsp_card_decode u_decode (
        .chars      (chars),
        .card_value (card_value)
    );

    // Debounce decision.
    assign fresh = !last_valid_reg || (text != last_chars_reg) ||
                   (ticks_reg > {1'b0, debounce_reg});

    // Next frame fill level; a byte with no frame open leaves it alone.
    always_comb begin
        fill_next = fill_reg;
        if (take && !is_tick) begin
            priority if (is_start) begin
                fill_next = FILL_W'(1);
            end else if (frame_done) begin
                fill_next = '0;
            end else if (frame_open) begin
                fill_next = fill_reg + FILL_W'(1);
            end else begin
                fill_next = fill_reg;
            end
        end
    end

    // Next tick count and scan total.
    always_comb begin
        ticks_next = ticks_reg;
        total_next = total_reg;
        if (take) begin
            if (is_tick) begin
                if (ticks_reg != '1) begin
                    ticks_next = ticks_reg + TICK_W'(1);
                end
            end else if (result && fresh) begin
                ticks_next = '0;
                total_next = total_reg + 32'd1;
            end
        end
    end

    // Frame state and card history.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            last_chars_reg <= '0;
            last_valid_reg <= 1'b0;
            ticks_reg      <= '0;
            total_reg      <= '0;
        end else begin
            fill_reg  <= fill_next;
            ticks_reg <= ticks_next;
            total_reg <= total_next;
            if (take && result && fresh) begin
                last_chars_reg <= text;
                last_valid_reg <= 1'b1;
            end
        end
    end

    // Frame byte store; byte k of the frame lands in entry k-1.
    always_ff @(posedge aclk) begin
        if (take && !is_tick && !is_start && frame_open) begin
            store_reg[store_idx] <= in_byte_reg;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= take && result;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && result) begin
            out_data_reg <= {total_next, text, card_value};
            out_new_reg  <= fresh;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_new_reg;

`ifndef NO_ASSERTIONS
    // A frame never holds more bytes than the store has entries.
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(STORE_DEPTH))
        else $error("frame fill level out of range");

    // A new scan bumps the total by exactly one.
    a_total_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && result && fresh) |=> (total_reg == $past(total_reg) + 32'd1))
        else $error("scan total did not advance on a new scan");

    // A new scan restarts the debounce window.
    a_ticks_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && result && fresh) |=> (ticks_reg == '0) && last_valid_reg)
        else $error("debounce window not restarted on a new scan");
`endif

endmodule
